### sv/cache_port_bandwidth_scheduler_top_macros.svh
// Assertion macros for the cache port bandwidth scheduler checker.
// Needs a clk and rst_n in the scope of use.
`ifndef CACHE_PORT_BANDWIDTH_SCHEDULER_TOP_MACROS_SVH
`define CACHE_PORT_BANDWIDTH_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define CPBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpbs assertion failed");

// next-cycle implication
`define CPBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpbs assertion failed");

`endif

### sv/cpbs_pkg.sv
// Shared types and codes for the cache port bandwidth scheduler.
// No dependencies.
package cpbs_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam int TIME_BITS = 48;

  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PORT_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SER_CYCLES = 2'd2;

  typedef struct packed {
    logic                 operation;
    logic [TIME_BITS-1:0] current_time;
    logic [15:0]          min_latency;
    logic [31:0]          access_address;
    logic [15:0]          request_tag;
    logic                 notify_wanted;
    logic [31:0]          entry_id;
  } req_t;

  typedef struct packed {
    logic [31:0] latency;
    logic [31:0] assigned_id;
    logic        finished;
    logic [31:0] finished_address;
    logic [15:0] finished_tag;
    logic        entry_found;
    logic [5:0]  queue_count;
    logic        overflow;
    logic        short_latency_error;
  } res_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] address;
    logic [15:0] tag;
    logic        notify;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic        pop;
    logic        push_wr;
    logic [31:0] target;
  } cell_op_t;

  // per-cell position flags
  typedef struct packed {
    logic live;
    logic tail;
  } cell_ctl_t;

endpackage

### sv/cpbs_cell.sv
// One table slot of the scheduler: holds an entry, matches ids on pop and
// shifts in from its right neighbour. Depends on cpbs_pkg.
module cpbs_cell #(
  parameter int TIME_W = 48
) (
  input  logic                clk,
  input  cpbs_pkg::cell_op_t  op_i,
  input  cpbs_pkg::cell_ctl_t ctl_i,
  input  cpbs_pkg::entry_t    new_i,
  input  logic [TIME_W-1:0]   new_end_i,
  input  cpbs_pkg::entry_t    nbr_i,
  input  logic [TIME_W-1:0]   nbr_end_i,
  input  logic                match_i,
  output logic                match_o,
  output logic                first_o,
  output cpbs_pkg::entry_t    entry_o,
  output logic [TIME_W-1:0]   end_o
);

  cpbs_pkg::entry_t  entry_r;
  logic [TIME_W-1:0] end_r;
  logic              hit;

  assign hit     = ctl_i.live && (entry_r.id == op_i.target);
  assign match_o = match_i || hit;
  assign first_o = hit && !match_i;
  assign entry_o = entry_r;
  assign end_o   = end_r;

  always_ff @(posedge clk) begin
    if (op_i.pop && match_o) begin
      entry_r <= nbr_i;
      end_r   <= nbr_end_i;
    end else if (op_i.push_wr && ctl_i.tail) begin
      entry_r <= new_i;
      end_r   <= new_end_i;
    end
  end

endmodule

### sv/cache_port_bandwidth_scheduler_top.sv
// Cache port bandwidth scheduler top level: config registers, control FSM
// and the row of cpbs_cell slots. Depends on cpbs_pkg and cpbs_cell.
//
// A pop, a bypassed push or a rejected push gives its result on out_valid
// in the cycle after start is taken, and busy stays low, so one such request
// can be taken every cycle. A scheduled push raises busy through S_SEND and
// S_LAT and gives its result when S_LAT ends: the accepting cycle picks the start time,
// S_SEND adds the serialized cycles and forms the start offset, S_LAT adds the minimum
// latency with saturation and writes the entry. out_valid is a one-cycle
// strobe; the receiver must take it. The user is to write config while busy is low; the block does not enforce it.
module cache_port_bandwidth_scheduler_top #(
  parameter int QUEUE_DEPTH = 32,
  parameter int MAX_PORTS   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  cpbs_pkg::req_t                      in_req,
  output logic                                out_valid,
  output cpbs_pkg::res_t                      out_res,
  input  logic                                cfg_we,
  input  logic [cpbs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cpbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int TIME_BITS = cpbs_pkg::TIME_BITS;
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int PORT_W = $clog2(MAX_PORTS + 1);
  localparam int CW     = (OCC_W > PORT_W) ? OCC_W : PORT_W;
  localparam int QW     = (OCC_W > 6) ? OCC_W : 6;
  localparam int LW     = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

  typedef enum logic [1:0] {S_IDLE, S_SEND, S_LAT} state_t;

  state_t            state_r;
  logic              out_valid_r;
  cpbs_pkg::res_t    out_res_r;
  cpbs_pkg::res_t    out_res_nxt;
  logic [OCC_W-1:0]  occ_r;
  logic [31:0]       next_id_r;
  logic              cfg_enable_r;
  logic [3:0]        cfg_ports_r;
  logic [7:0]        cfg_ser_r;
  logic [TIME_BITS-1:0] start_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] send_r;
  logic [TIME_BITS-1:0] diff_r;
  logic [15:0]          minlat_r;
  cpbs_pkg::entry_t     pend_r;

  cpbs_pkg::entry_t     cell_entry [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] cell_end   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] match_chain;
  logic [QUEUE_DEPTH-1:0] first;
  cpbs_pkg::cell_op_t   cell_op;

  logic                 accept;
  logic [PORT_W-1:0]    ports_eff;
  logic                 bypass;
  logic                 full;
  logic                 shortlat;
  logic                 use_end;
  logic [CW-1:0]        back_idx;
  logic [TIME_BITS-1:0] now_c;
  logic [TIME_BITS-1:0] end_sel;
  logic [TIME_BITS-1:0] start_c;
  logic [TIME_BITS:0]   send_sum;
  logic [LW-1:0]        lat_sum;
  cpbs_pkg::entry_t     pop_entry;
  logic                 pop_hit;

  function automatic logic [5:0] to_count(input logic [OCC_W-1:0] v);
    logic [QW-1:0] w;
    w = QW'(v);
    return w[5:0];
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign ports_eff = (32'(cfg_ports_r) > 32'(MAX_PORTS)) ? PORT_W'(MAX_PORTS)
                                                         : PORT_W'(cfg_ports_r);
  assign bypass    = !cfg_enable_r || (cfg_ports_r == 4'd0) || (cfg_ser_r == 8'd0);
  assign full      = (occ_r >= OCC_W'(QUEUE_DEPTH));
  assign shortlat  = (in_req.min_latency < {8'd0, cfg_ser_r});
  assign use_end   = (CW'(occ_r) >= CW'(ports_eff));
  assign back_idx  = CW'(occ_r) - CW'(ports_eff);
  assign now_c     = TIME_BITS'(in_req.current_time);
  assign end_sel   = cell_end[back_idx[IDX_W-1:0]];
  assign start_c   = (use_end && (end_sel > now_c)) ? end_sel : now_c;
  assign send_sum  = (TIME_BITS+1)'(start_r) + (TIME_BITS+1)'(cfg_ser_r);
  assign lat_sum   = LW'(diff_r) + LW'(minlat_r);

  assign cell_op.pop     = accept && (in_req.operation == cpbs_pkg::OP_POP);
  assign cell_op.push_wr = (state_r == S_LAT);
  assign cell_op.target  = in_req.entry_id;

  assign match_chain[0] = 1'b0;
  assign pop_hit        = match_chain[QUEUE_DEPTH];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    cpbs_pkg::cell_ctl_t  ctl;
    cpbs_pkg::entry_t     nbr;
    logic [TIME_BITS-1:0] nbr_end;

    assign ctl.live = (32'(occ_r) > g);
    assign ctl.tail = (32'(occ_r) == g);

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nbr     = cell_entry[g];
      assign nbr_end = cell_end[g];
    end else begin : g_mid
      assign nbr     = cell_entry[g+1];
      assign nbr_end = cell_end[g+1];
    end

    cpbs_cell #(.TIME_W(TIME_BITS)) u_cell (
      .clk       (clk),
      .op_i      (cell_op),
      .ctl_i     (ctl),
      .new_i     (pend_r),
      .new_end_i (send_r),
      .nbr_i     (nbr),
      .nbr_end_i (nbr_end),
      .match_i   (match_chain[g]),
      .match_o   (match_chain[g+1]),
      .first_o   (first[g]),
      .entry_o   (cell_entry[g]),
      .end_o     (cell_end[g])
    );
  end

  always_comb begin
    pop_entry = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (first[i]) begin
        pop_entry = pop_entry | cell_entry[i];
      end
    end
  end

  always_comb begin
    out_res_nxt = '0;
    if (state_r == S_LAT) begin
      out_res_nxt.latency     = (lat_sum > LW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                               : lat_sum[31:0];
      out_res_nxt.assigned_id = next_id_r;
      out_res_nxt.queue_count = to_count(occ_r + 1'b1);
    end else if (in_req.operation == cpbs_pkg::OP_POP) begin
      if (pop_hit) begin
        out_res_nxt.finished         = pop_entry.notify;
        out_res_nxt.finished_address = pop_entry.address;
        out_res_nxt.finished_tag     = pop_entry.tag;
        out_res_nxt.entry_found      = 1'b1;
        out_res_nxt.queue_count      = to_count(occ_r - 1'b1);
      end else begin
        out_res_nxt.queue_count = to_count(occ_r);
      end
    end else if (bypass) begin
      out_res_nxt.latency          = 32'(in_req.min_latency);
      out_res_nxt.finished         = in_req.notify_wanted;
      out_res_nxt.finished_address = in_req.access_address;
      out_res_nxt.finished_tag     = in_req.request_tag;
      out_res_nxt.queue_count      = to_count(occ_r);
    end else begin
      out_res_nxt.overflow            = full;
      out_res_nxt.short_latency_error = shortlat;
      out_res_nxt.queue_count         = to_count(occ_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      occ_r        <= '0;
      next_id_r    <= '0;
      cfg_enable_r <= 1'b0;
      cfg_ports_r  <= 4'd1;
      cfg_ser_r    <= 8'd1;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          cpbs_pkg::REG_ENABLE:     cfg_enable_r <= cfg_wdata[0];
          cpbs_pkg::REG_PORT_COUNT: cfg_ports_r  <= cfg_wdata[3:0];
          cpbs_pkg::REG_SER_CYCLES: cfg_ser_r    <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_req.operation == cpbs_pkg::OP_POP) begin
              out_valid_r <= 1'b1;
              out_res_r   <= out_res_nxt;
              if (pop_hit) begin
                occ_r <= occ_r - 1'b1;
              end
            end else if (bypass || full || shortlat) begin
              out_valid_r <= 1'b1;
              out_res_r   <= out_res_nxt;
            end else begin
              start_r        <= start_c;
              now_r          <= now_c;
              minlat_r       <= in_req.min_latency;
              pend_r.id      <= next_id_r;
              pend_r.address <= in_req.access_address;
              pend_r.tag     <= in_req.request_tag;
              pend_r.notify  <= in_req.notify_wanted;
              state_r        <= S_SEND;
            end
          end
        end
        S_SEND: begin
          send_r  <= send_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : send_sum[TIME_BITS-1:0];
          diff_r  <= start_r - now_r;
          state_r <= S_LAT;
        end
        S_LAT: begin
          out_valid_r <= 1'b1;
          out_res_r   <= out_res_nxt;
          occ_r       <= occ_r + 1'b1;
          next_id_r   <= next_id_r + 32'd1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/cpbs_checker.sv
// Port-level checks for the cache port bandwidth scheduler, bound to the top.
// Depends on cpbs_pkg and cache_port_bandwidth_scheduler_top_macros.svh.
`include "cache_port_bandwidth_scheduler_top_macros.svh"

module cpbs_checker #(
  parameter int QUEUE_DEPTH = 32
) (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input cpbs_pkg::req_t in_req,
  input logic           out_valid,
  input cpbs_pkg::res_t out_res
);

  `CPBS_ASSERT_NXT(a_pop_next, start && !busy && (in_req.operation == cpbs_pkg::OP_POP), out_valid && !out_res.overflow)
  `CPBS_ASSERT_NXT(a_req_progress, start && !busy, out_valid || busy)
  `CPBS_ASSERT_IMP(a_busy_ends_with_result, $fell(busy), out_valid)
  `CPBS_ASSERT_IMP(a_overflow_full, out_valid && out_res.overflow, out_res.queue_count == 6'(QUEUE_DEPTH))

endmodule

bind cache_port_bandwidth_scheduler_top cpbs_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_cpbs_checker (.*);

### bench/cache_port_bandwidth_scheduler_top_tb.sv
// Self-checking bench for cache_port_bandwidth_scheduler_top: directed and random
// push/pop requests against a port-serialisation predictor held in a scoreboard class.
// Depends on cpbs_pkg and the scheduler RTL.
module cache_port_bandwidth_scheduler_top_tb;
  import cpbs_pkg::*;

  localparam int DEPTH = 32;
  localparam int PORTS_MAX = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [63:0] TIME_ALL = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] id;
    logic [63:0] serial_end;
    logic [31:0] address;
    logic [15:0] tag;
    logic        notify;
  } flight_t;

  class port_schedule_predictor;
    flight_t in_flight[$];
    res_t    expected[$];
    logic [31:0] next_id;
    logic        en;
    logic [3:0]  ports;
    logic [7:0]  ser;
    int          failures;

    function new();
      next_id = '0;
      en = 1'b0;
      ports = 4'd1;
      ser = 8'd1;
      failures = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ENABLE:     en = val[0];
        REG_PORT_COUNT: ports = val[3:0];
        REG_SER_CYCLES: ser = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function int occupancy();
      return in_flight.size();
    endfunction

    function logic [31:0] live_id(int k);
      return in_flight[k].id;
    endfunction

    function void note_request(req_t r);
      res_t    x;
      int      lanes;
      int      k;
      logic [63:0] st;
      logic [63:0] send;
      logic [63:0] diff;
      flight_t f;
      x = '0;
      if (r.operation == OP_PUSH) begin
        lanes = (ports > PORTS_MAX) ? PORTS_MAX : int'(ports);
        if (!en || lanes == 0 || ser == 8'd0) begin
          x.latency = {16'd0, r.min_latency};
          x.finished = r.notify_wanted;
          x.finished_address = r.access_address;
          x.finished_tag = r.request_tag;
        end else if (in_flight.size() >= DEPTH || r.min_latency < {8'd0, ser}) begin
          x.overflow = (in_flight.size() >= DEPTH);
          x.short_latency_error = (r.min_latency < {8'd0, ser});
        end else begin
          st = {16'd0, r.current_time};
          if (in_flight.size() >= lanes &&
              in_flight[in_flight.size() - lanes].serial_end > st)
            st = in_flight[in_flight.size() - lanes].serial_end;
          if (st > TIME_ALL - {56'd0, ser})
            send = TIME_ALL;
          else
            send = st + {56'd0, ser};
          diff = st - {16'd0, r.current_time};
          if (diff > 64'hFFFF_FFFF - {48'd0, r.min_latency})
            x.latency = 32'hFFFF_FFFF;
          else
            x.latency = diff[31:0] + {16'd0, r.min_latency};
          x.assigned_id = next_id;
          f.id = next_id;
          f.serial_end = send;
          f.address = r.access_address;
          f.tag = r.request_tag;
          f.notify = r.notify_wanted;
          in_flight.insert(in_flight.size(), f);
          next_id = next_id + 32'd1;
        end
      end else begin
        for (k = 0; k < in_flight.size(); k++)
          if (in_flight[k].id == r.entry_id) break;
        if (k < in_flight.size()) begin
          x.entry_found = 1'b1;
          x.finished = in_flight[k].notify;
          x.finished_address = in_flight[k].address;
          x.finished_tag = in_flight[k].tag;
          in_flight.delete(k);
        end
      end
      x.queue_count = 6'(in_flight.size());
      expected.insert(expected.size(), x);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected.size() == 0) begin
        $error("result strobe with no request outstanding");
        failures++;
        return;
      end
      want = expected.pop_front();
      compare_field("latency", want.latency, got.latency);
      compare_field("assigned_id", want.assigned_id, got.assigned_id);
      compare_field("finished", want.finished, got.finished);
      compare_field("finished_address", want.finished_address, got.finished_address);
      compare_field("finished_tag", want.finished_tag, got.finished_tag);
      compare_field("entry_found", want.entry_found, got.entry_found);
      compare_field("queue_count", want.queue_count, got.queue_count);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("short_latency_error", want.short_latency_error,
                    got.short_latency_error);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t in_req = '0;
  logic out_valid;
  res_t out_res;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  port_schedule_predictor book = new();
  int cycles = 0;
  logic [47:0] sim_now = 48'd0;
  bit no_gaps = 1'b0;
  int push_weight = 60;

  cache_port_bandwidth_scheduler_top #(
    .QUEUE_DEPTH(DEPTH),
    .MAX_PORTS(PORTS_MAX)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) book.check_result(out_res);
  end

  // called at a rising edge; returns at the edge where the request is taken
  task automatic issue_request(req_t r);
    start <= 1'b1;
    in_req <= r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    book.note_request(r);
  endtask

  task automatic sender_gap();
    int n;
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 50) return;
    if (roll < 85) n = $urandom_range(1, 3);
    else if (roll < 97) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 60);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    book.set_reg(idx, val);
    @(posedge clk);
  endtask

  // all three registers, upper data bits random where they are ignored
  task automatic configure(logic en, logic [3:0] pc, logic [7:0] sc);
    write_reg(REG_ENABLE, {7'($urandom), en});
    write_reg(REG_PORT_COUNT, {4'($urandom), pc});
    write_reg(REG_SER_CYCLES, sc);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t push_req(logic [47:0] t, logic [15:0] ml);
    req_t r;
    r = '0;
    r.operation = OP_PUSH;
    r.current_time = t;
    r.min_latency = ml;
    r.access_address = $urandom;
    r.request_tag = 16'($urandom);
    r.notify_wanted = 1'($urandom);
    r.entry_id = $urandom;
    return r;
  endfunction

  function automatic req_t pop_req(logic [31:0] id);
    req_t r;
    r = '0;
    r.operation = OP_POP;
    r.current_time = {16'($urandom), 32'($urandom)};
    r.min_latency = 16'($urandom);
    r.access_address = $urandom;
    r.request_tag = 16'($urandom);
    r.notify_wanted = 1'($urandom);
    r.entry_id = id;
    return r;
  endfunction

  function automatic req_t random_request();
    int roll;
    logic [15:0] ml;
    logic [31:0] id;
    roll = $urandom_range(0, 99);
    if (roll < 90) sim_now = sim_now + 48'($urandom_range(0, 3));
    else if (roll < 97) sim_now = sim_now + 48'($urandom_range(4, 2000));
    else sim_now = {16'($urandom), 32'($urandom)};
    if ($urandom_range(0, 99) < push_weight) begin
      roll = $urandom_range(0, 99);
      if (book.ser == 8'd0) ml = 16'($urandom_range(0, 400));
      else if (roll < 80) ml = {8'd0, book.ser} + 16'($urandom_range(0, 200));
      else if (roll < 90) ml = 16'($urandom);
      else ml = 16'($urandom_range(0, book.ser - 1));
      return push_req(sim_now, ml);
    end
    if (book.occupancy() > 0 && $urandom_range(0, 99) < 85)
      id = book.live_id($urandom_range(0, book.occupancy() - 1));
    else
      id = $urandom;
    return pop_req(id);
  endfunction

  initial begin
    req_t r;
    int ph;
    int n;
    logic [3:0] pc;
    logic [7:0] sc;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: modelling off, every push bypasses
    r = push_req(48'hFFFF_FFFF_FFFF, 16'hFFFF);
    r.access_address = 32'hFFFF_FFFF;
    r.request_tag = 16'hFFFF;
    r.notify_wanted = 1'b1;
    r.entry_id = 32'hFFFF_FFFF;
    issue_request(r);
    r = '0;
    issue_request(r);
    issue_request(pop_req(32'hFFFF_FFFF));
    wait_idle();

    configure(1'b1, 4'd1, 8'd1);
    issue_request(push_req(48'd100, 16'd0));
    issue_request(push_req(48'd100, 16'd1));
    issue_request(push_req(48'd100, 16'd5));
    issue_request(pop_req(32'd0));
    issue_request(pop_req(32'd0));
    issue_request(pop_req(32'd1));
    wait_idle();

    // serialisation end saturates, then the 32-bit latency saturates
    configure(1'b1, 4'd1, 8'd255);
    issue_request(push_req(48'hFFFF_FFFF_FFFC, 16'd255));
    issue_request(push_req(48'd0, 16'hFFFF));
    issue_request(push_req(48'd0, 16'd254));
    issue_request(pop_req(32'd2));
    issue_request(pop_req(32'd3));
    wait_idle();

    // port count above the maximum behaves as the maximum
    configure(1'b1, 4'd15, 8'd16);
    for (n = 0; n < 9; n++) issue_request(push_req(48'd1000, 16'd16 + 16'(n)));
    wait_idle();
    configure(1'b1, 4'd0, 8'd16);
    issue_request(push_req(48'd1000, 16'd20));
    wait_idle();
    configure(1'b1, 4'd8, 8'd0);
    issue_request(push_req(48'd1000, 16'd3));
    wait_idle();

    for (ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 5))
        0: pc = 4'd0;
        1: pc = 4'd1;
        2: pc = 4'd8;
        3: pc = 4'd15;
        default: pc = 4'($urandom_range(1, 15));
      endcase
      case ($urandom_range(0, 4))
        0: sc = 8'd0;
        1: sc = 8'd1;
        2: sc = 8'd255;
        default: sc = 8'($urandom);
      endcase
      if (ph == 0) begin
        pc = 4'd1;
        sc = 8'd1;
      end else if (ph == 1) begin
        pc = 4'd8;
        sc = 8'd255;
      end
      configure((ph == 2) ? 1'b0 : ($urandom_range(0, 9) != 0), pc, sc);
      no_gaps = (ph % 3 == 1);
      push_weight = (ph % 4 == 1) ? 90 : $urandom_range(40, 70);
      for (n = 0; n < 80; n++) begin
        sender_gap();
        issue_request(random_request());
        if ($urandom_range(0, 99) == 0) wait_idle();
      end
      wait_idle();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (book.pending() != 0) begin
      $error("%0d expected results never arrived", book.pending());
      book.failures++;
    end
    if (book.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
